/* hw/rtl/lsf_pkg.sv */
`timescale 1ns / 1ps

package lsf_pkg;

    // Defaults and upper bounds of the top-level parameters.
    localparam int WORD_BITS_DEF = 16;
    localparam int ADDR_BITS_DEF = 6;
    localparam int WORD_BITS_MAX = 32;
    localparam int ADDR_BITS_MAX = 8;

    // Fixed field widths of the item port.
    localparam int ADDR_FIELD_W = 6;
    localparam int COUNT_W      = 5;

    // Frame ID codes, sent MSB first.
    localparam int ID_W = 3;
    localparam logic [ID_W-1:0] ID_COMMAND    = 3'd4;
    localparam logic [ID_W-1:0] ID_WRITE_DATA = 3'd5;

    localparam int CMD_BITS = 8;

    localparam logic MODE_COMMAND = 1'b0;
    localparam logic MODE_DATA    = 1'b1;

    localparam int HDR_W      = ID_W + ADDR_BITS_MAX;
    localparam int HDR_CNT_W  = $clog2(HDR_W + 1);
    localparam int BODY_W     = WORD_BITS_MAX;
    localparam int BODY_CNT_W = $clog2(BODY_W + 1);

    localparam int QUEUE_DEPTH = 2;

    // One classified item: a header sent MSB first from the top bit, a body
    // sent LSB first, and an optional trailing dummy pulse.
    typedef struct packed {
        logic [HDR_W-1:0]      hdr;
        logic [HDR_CNT_W-1:0]  hdr_len;
        logic [BODY_W-1:0]     body;
        logic [BODY_CNT_W-1:0] body_len;
        logic                  dummy;
        logic                  sel;
        logic                  rel;
    } job_t;

endpackage

/* hw/rtl/lcd_driver_serial_frame_sender_top.sv */
`timescale 1ns / 1ps

// Three-wire serial write framer for a segment LCD controller. Every accepted
// item becomes a run of write-strobe pulses, one per header, body or dummy bit: a
// command item gives 9 or 12 pulses, a data item from 1 to 3 + ADDR_BITS +
// WORD_BITS pulses (25 with the defaults), and a data item that neither opens
// a frame nor carries bits gives none. The back-end sequencer emits at most one
// pulse per cycle unless pulse_stall holds one back, and loads the next item
// once the current one is done. The front end classifies items into a two-entry
// queue, so up to two items can be accepted ahead of the one being sent, and a
// finished pulse sits in an output register while the next is made.
module lcd_driver_serial_frame_sender_top #(
    parameter int WORD_BITS = lsf_pkg::WORD_BITS_DEF,
    parameter int ADDR_BITS = lsf_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              mode,
    input  logic                              opens_frame,
    input  logic                              closes_frame,
    input  logic [lsf_pkg::ADDR_FIELD_W-1:0]  start_address,
    input  logic [WORD_BITS-1:0]              payload,
    input  logic [lsf_pkg::COUNT_W-1:0]       bit_count,
    output logic                              pulse_valid,
    input  logic                              pulse_stall,
    output logic                              data_bit,
    output logic                              select_active,
    output logic                              dummy_pulse,
    output logic                              last_of_run,
    output logic                              select_released
);
    import lsf_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_head_valid;
    job_t q_push_job;
    job_t q_head_job;

    lsf_front #(
        .WORD_BITS (WORD_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .opens_frame   (opens_frame),
        .closes_frame  (closes_frame),
        .start_address (start_address),
        .payload       (payload),
        .bit_count     (bit_count),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_push_job)
    );

    lsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    lsf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_head_valid),
        .head_job        (q_head_job),
        .pop             (q_pop),
        .pulse_valid     (pulse_valid),
        .pulse_stall     (pulse_stall),
        .data_bit        (data_bit),
        .select_active   (select_active),
        .dummy_pulse     (dummy_pulse),
        .last_of_run     (last_of_run),
        .select_released (select_released)
    );

endmodule

/* hw/rtl/lsf_front.sv */
`timescale 1ns / 1ps

module lsf_front #(
    parameter int WORD_BITS = lsf_pkg::WORD_BITS_DEF,
    parameter int ADDR_BITS = lsf_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              mode,
    input  logic                              opens_frame,
    input  logic                              closes_frame,
    input  logic [lsf_pkg::ADDR_FIELD_W-1:0]  start_address,
    input  logic [WORD_BITS-1:0]              payload,
    input  logic [lsf_pkg::COUNT_W-1:0]       bit_count,
    input  logic                              q_full,
    output logic                              q_push,
    output lsf_pkg::job_t                     q_job
);
    import lsf_pkg::*;

    logic                  frame_open_reg;
    logic                  frame_open_next;
    logic                  accept;
    logic                  sel;
    logic                  has_pulse;
    logic [BODY_CNT_W-1:0] cnt_ext;
    logic [BODY_CNT_W-1:0] cnt_sat;
    logic [ADDR_BITS-1:0]  addr_ext;

    assign item_stall = q_full;
    assign accept     = item_valid && !item_stall;
    assign sel        = opens_frame || frame_open_reg;
    assign cnt_ext    = BODY_CNT_W'(bit_count);
    assign cnt_sat    = (cnt_ext > BODY_CNT_W'(WORD_BITS)) ? BODY_CNT_W'(WORD_BITS) : cnt_ext;
    assign addr_ext   = ADDR_BITS'(start_address);

    always_comb
    begin
        q_job = '0;
        q_job.sel = sel;
        q_job.rel = closes_frame && sel;
        unique case (mode)
            MODE_COMMAND:
            begin
                q_job.hdr      = {ID_COMMAND, (HDR_W-ID_W)'(0)};
                q_job.hdr_len  = opens_frame ? HDR_CNT_W'(ID_W) : '0;
                // Command bits go out MSB first, so reverse them into the body.
                for (int i = 0; i < CMD_BITS; i++)
                begin
                    q_job.body[i] = payload[CMD_BITS-1-i];
                end
                q_job.body_len = BODY_CNT_W'(CMD_BITS);
                q_job.dummy    = 1'b1;
            end
            MODE_DATA:
            begin
                q_job.hdr      = HDR_W'({ID_WRITE_DATA, addr_ext}) << (ADDR_BITS_MAX - ADDR_BITS);
                q_job.hdr_len  = opens_frame ? HDR_CNT_W'(ID_W + ADDR_BITS) : '0;
                q_job.body     = BODY_W'(payload);
                q_job.body_len = cnt_sat;
                q_job.dummy    = 1'b0;
            end
            default:
            begin
                q_job = '0;
            end
        endcase
    end

    // A data item that neither opens a frame nor carries bits makes no pulse,
    // but still moves the frame state.
    assign has_pulse = (mode == MODE_COMMAND) || opens_frame || (cnt_sat != '0);
    assign q_push    = accept && has_pulse;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        if (accept)
        begin
            frame_open_next = closes_frame ? 1'b0 : sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

/* hw/rtl/lsf_queue.sv */
`timescale 1ns / 1ps

module lsf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lsf_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output lsf_pkg::job_t head_job
);
    import lsf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/lsf_back.sv */
`timescale 1ns / 1ps

module lsf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  lsf_pkg::job_t head_job,
    output logic          pop,
    output logic          pulse_valid,
    input  logic          pulse_stall,
    output logic          data_bit,
    output logic          select_active,
    output logic          dummy_pulse,
    output logic          last_of_run,
    output logic          select_released
);
    import lsf_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  level_reg;
    logic                  level_next;
    logic                  pv_reg;
    logic                  pv_next;
    logic [HDR_W-1:0]      hdr_reg;
    logic [HDR_CNT_W-1:0]  hdr_cnt_reg;
    logic [BODY_W-1:0]     body_reg;
    logic [BODY_CNT_W-1:0] body_cnt_reg;
    logic                  dummy_reg;
    logic                  sel_reg;
    logic                  rel_reg;
    logic [HDR_CNT_W-1:0]  hdr_cnt_next;
    logic [BODY_CNT_W-1:0] body_cnt_next;
    logic                  dummy_next;
    logic                  hdr_phase;
    logic                  body_phase;
    logic                  cur_bit;
    logic                  cur_dummy;
    logic                  cur_last;
    logic                  advance;
    logic                  out_bit_reg;
    logic                  out_sel_reg;
    logic                  out_dummy_reg;
    logic                  out_last_reg;
    logic                  out_rel_reg;

    assign pop        = !busy_reg && head_valid;
    assign advance    = busy_reg && (!pv_reg || !pulse_stall);
    assign hdr_phase  = (hdr_cnt_reg != '0);
    assign body_phase = !hdr_phase && (body_cnt_reg != '0);
    assign cur_dummy  = !hdr_phase && !body_phase;

    always_comb
    begin
        priority if (hdr_phase)
        begin
            cur_bit = hdr_reg[HDR_W-1];
        end
        else if (body_phase)
        begin
            cur_bit = body_reg[0];
        end
        else
        begin
            // The dummy pulse repeats whatever level the data line holds.
            cur_bit = level_reg;
        end
    end

    assign hdr_cnt_next  = hdr_phase ? hdr_cnt_reg - 1'b1 : hdr_cnt_reg;
    assign body_cnt_next = body_phase ? body_cnt_reg - 1'b1 : body_cnt_reg;
    assign dummy_next    = cur_dummy ? 1'b0 : dummy_reg;
    assign cur_last      = (hdr_cnt_next == '0) && (body_cnt_next == '0) && !dummy_next;

    always_comb
    begin
        busy_next  = busy_reg;
        level_next = level_reg;
        pv_next    = pv_reg && pulse_stall;
        if (pop)
        begin
            busy_next = 1'b1;
        end
        if (advance)
        begin
            pv_next = 1'b1;
            if (!cur_dummy)
            begin
                level_next = cur_bit;
            end
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            level_reg <= 1'b1;
            pv_reg    <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hdr_reg      <= head_job.hdr;
            hdr_cnt_reg  <= head_job.hdr_len;
            body_reg     <= head_job.body;
            body_cnt_reg <= head_job.body_len;
            dummy_reg    <= head_job.dummy;
            sel_reg      <= head_job.sel;
            rel_reg      <= head_job.rel;
        end
        else if (advance)
        begin
            if (hdr_phase)
            begin
                hdr_reg <= {hdr_reg[HDR_W-2:0], 1'b0};
            end
            if (body_phase)
            begin
                body_reg <= {1'b0, body_reg[BODY_W-1:1]};
            end
            hdr_cnt_reg  <= hdr_cnt_next;
            body_cnt_reg <= body_cnt_next;
            dummy_reg    <= dummy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_bit_reg   <= cur_bit;
            out_sel_reg   <= sel_reg;
            out_dummy_reg <= cur_dummy;
            out_last_reg  <= cur_last;
            out_rel_reg   <= cur_last && rel_reg;
        end
    end

    assign pulse_valid     = pv_reg;
    assign data_bit        = out_bit_reg;
    assign select_active   = out_sel_reg;
    assign dummy_pulse     = out_dummy_reg;
    assign last_of_run     = out_last_reg;
    assign select_released = out_rel_reg;

endmodule
